[rtl/core/dda_line_rasterizer_top_macros.svh]
// assertion macros shared by the line rasterizer rtl
`ifndef DDA_LINE_RASTERIZER_TOP_MACROS_SVH
`define DDA_LINE_RASTERIZER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define DLR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dlr assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define DLR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dlr assertion failed");

`endif

[rtl/core/dlr_pkg.sv]
// shared types and constants of the line rasterizer
`default_nettype none

package dlr_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned STRIDE_W  = 16;
  localparam int unsigned PBITS_W   = 6;
  localparam int unsigned BPP_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BITS = 2'd2;

  localparam logic [PBITS_W-1:0] PIXEL_BITS_RST = 6'd32;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch endpoints and color
    logic setup;  // deltas, directions, start products
    logic init;   // span, error terms, start address
    logic emit;   // push a pixel and advance the walker
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a pixel
    logic last;      // current pixel ends the segment
  } status_t;

endpackage

`default_nettype wire

[rtl/core/dlr_datapath.sv]
// line walker, address generation and output register
`default_nettype none

module dlr_datapath #(
  parameter int unsigned CoordBits = 12,
  parameter int unsigned MaxSpan   = 63
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  dlr_pkg::cmd_t                    cmd_i,
  output dlr_pkg::status_t                 status_o,
  input  wire  [CoordBits-1:0]             x_start_i,
  input  wire  [CoordBits-1:0]             y_start_i,
  input  wire  [CoordBits-1:0]             x_end_i,
  input  wire  [CoordBits-1:0]             y_end_i,
  input  wire  [dlr_pkg::COLOR_W-1:0]      line_color_i,
  input  wire  [dlr_pkg::ADDR_W-1:0]       frame_base_i,
  input  wire  [dlr_pkg::STRIDE_W-1:0]     row_stride_i,
  input  wire  [dlr_pkg::BPP_W-1:0]        byte_step_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [CoordBits-1:0]             pixel_x_o,
  output logic [CoordBits-1:0]             pixel_y_o,
  output logic [dlr_pkg::ADDR_W-1:0]       pixel_address_o,
  output logic [dlr_pkg::COLOR_W-1:0]      pixel_color_o,
  output logic                             last_pixel_o,
  output logic                             cut_short_o
);

  localparam int unsigned CntW   = $clog2(MaxSpan + 1);
  localparam int unsigned ProdYW = CoordBits + dlr_pkg::STRIDE_W;
  localparam int unsigned ProdXW = CoordBits + dlr_pkg::BPP_W;

  // segment registers
  logic [CoordBits-1:0]        x0_q, y0_q, x1_q, y1_q;
  logic [dlr_pkg::COLOR_W-1:0] color_q;
  logic [CoordBits-1:0]        ax_q, ay_q, span_q;
  logic                        negx_q, negy_q, cut_q;
  logic [dlr_pkg::ADDR_W-1:0]  prody_q, prodx_q, dxa_q, dya_q, addr_q;
  logic [CoordBits-1:0]        curx_q, cury_q, errx_q, erry_q;
  logic [CntW-1:0]             idx_q, total_q;
  logic                        out_valid_q;

  // setup stage
  logic                 negx_w, negy_w;
  logic [ProdYW-1:0]    prody_w;
  logic [ProdXW-1:0]    prodx_w;

  assign negx_w  = x1_q < x0_q;
  assign negy_w  = y1_q < y0_q;
  assign prody_w = y0_q * row_stride_i;
  assign prodx_w = x0_q * byte_step_i;

  // init stage
  logic [CoordBits-1:0]       span_w;
  logic                       cut_w;
  logic [dlr_pkg::ADDR_W-1:0] bpp_ext, stride_ext;

  assign span_w     = (ax_q > ay_q) ? ax_q : ay_q;
  assign cut_w      = span_w > CoordBits'(MaxSpan);
  assign bpp_ext    = {{(dlr_pkg::ADDR_W - dlr_pkg::BPP_W){1'b0}}, byte_step_i};
  assign stride_ext = {{(dlr_pkg::ADDR_W - dlr_pkg::STRIDE_W){1'b0}}, row_stride_i};

  // walker step: one compare and subtract per axis
  logic [CoordBits:0]         sumx_w, sumy_w;
  logic                       stepx_w, stepy_w;
  logic [CoordBits:0]         remx_w, remy_w;
  logic [dlr_pkg::ADDR_W-1:0] addr_next_w;

  assign sumx_w  = {1'b0, errx_q} + {1'b0, ax_q};
  assign sumy_w  = {1'b0, erry_q} + {1'b0, ay_q};
  assign stepx_w = sumx_w >= {1'b0, span_q};
  assign stepy_w = sumy_w >= {1'b0, span_q};
  assign remx_w  = sumx_w - {1'b0, span_q};
  assign remy_w  = sumy_w - {1'b0, span_q};
  assign addr_next_w = addr_q + (stepx_w ? dxa_q : '0) + (stepy_w ? dya_q : '0);

  logic last_w;
  assign last_w = idx_q == total_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x0_q    <= x_start_i;
      y0_q    <= y_start_i;
      x1_q    <= x_end_i;
      y1_q    <= y_end_i;
      color_q <= line_color_i;
    end
    if (cmd_i.setup) begin
      negx_q  <= negx_w;
      negy_q  <= negy_w;
      ax_q    <= negx_w ? (x0_q - x1_q) : (x1_q - x0_q);
      ay_q    <= negy_w ? (y0_q - y1_q) : (y1_q - y0_q);
      prody_q <= dlr_pkg::ADDR_W'(prody_w);
      prodx_q <= dlr_pkg::ADDR_W'(prodx_w);
      curx_q  <= x0_q;
      cury_q  <= y0_q;
    end
    if (cmd_i.init) begin
      span_q  <= span_w;
      cut_q   <= cut_w;
      total_q <= cut_w ? CntW'(MaxSpan) : span_w[CntW-1:0];
      // ceiling bias for a falling axis
      errx_q  <= negx_q ? (span_w - 1'b1) : '0;
      erry_q  <= negy_q ? (span_w - 1'b1) : '0;
      dxa_q   <= negx_q ? (-bpp_ext) : bpp_ext;
      dya_q   <= negy_q ? (-stride_ext) : stride_ext;
      addr_q  <= frame_base_i + prody_q + prodx_q;
      idx_q   <= '0;
    end
    if (cmd_i.emit) begin
      pixel_x_o       <= curx_q;
      pixel_y_o       <= cury_q;
      pixel_address_o <= addr_q;
      pixel_color_o   <= color_q;
      last_pixel_o    <= last_w;
      cut_short_o     <= last_w && cut_q;
      errx_q <= stepx_w ? remx_w[CoordBits-1:0] : sumx_w[CoordBits-1:0];
      erry_q <= stepy_w ? remy_w[CoordBits-1:0] : sumy_w[CoordBits-1:0];
      if (stepx_w) begin
        curx_q <= negx_q ? (curx_q - 1'b1) : (curx_q + 1'b1);
      end
      if (stepy_w) begin
        cury_q <= negy_q ? (cury_q - 1'b1) : (cury_q + 1'b1);
      end
      addr_q <= addr_next_w;
      idx_q  <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign status_o.last     = last_w;

endmodule

`default_nettype wire

[rtl/core/dlr_ctrl.sv]
// sequencing state machine of the line rasterizer
`default_nettype none

module dlr_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  dlr_pkg::status_t status_i,
  output dlr_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_INIT  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;

endmodule

`default_nettype wire

[rtl/core/dda_line_rasterizer_top.sv]
// top level of the dda line rasterizer: config registers, controller and datapath
`default_nettype none

// Rasterizes one line segment per request: for endpoints (x0,y0)-(x1,y1) it
// emits steps+1 pixel requests, steps = max(|dx|,|dy|), pixel k at
// x0 + floor(k*dx/steps), y0 + floor(k*dy/steps), computed exactly with
// integer error terms. A zero-length segment yields one pixel. Segments
// longer than MAX_SPAN steps stop after MAX_SPAN+1 pixels and the final one
// has cut_short set. Each pixel carries the byte address
// frame_base + y*row_stride + x*(pixel_bits/8), modulo 2^32, plus the color.
// A segment goes through these steps: the request is taken; the deltas and
// the start products (y0*row_stride, x0*byte step) are formed; the span,
// error terms and start address are set; then the walker gives one pixel per
// cycle while the output is not stalled, and its per-step address update
// adds the row and column deltas to the previous address.
// The next segment is taken in the cycle after the last pixel has been
// loaded into the output register, while that pixel may still be waiting.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i:
// index 0 frame_base, 1 row_stride, 2 pixel_bits; other indexes are ignored.

`include "dda_line_rasterizer_top_macros.svh"

module dda_line_rasterizer_top #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned MAX_SPAN   = 63
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration write port
  input  wire                              cfg_we_i,
  input  wire  [dlr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [dlr_pkg::CFG_W-1:0]        cfg_data_i,
  // segment requests
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [COORD_BITS-1:0]            x_start_i,
  input  wire  [COORD_BITS-1:0]            y_start_i,
  input  wire  [COORD_BITS-1:0]            x_end_i,
  input  wire  [COORD_BITS-1:0]            y_end_i,
  input  wire  [dlr_pkg::COLOR_W-1:0]      line_color_i,
  // pixel requests
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [COORD_BITS-1:0]            pixel_x_o,
  output logic [COORD_BITS-1:0]            pixel_y_o,
  output logic [dlr_pkg::ADDR_W-1:0]       pixel_address_o,
  output logic [dlr_pkg::COLOR_W-1:0]      pixel_color_o,
  output logic                             last_pixel_o,
  output logic                             cut_short_o
);

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  logic [dlr_pkg::ADDR_W-1:0]   frame_base_q;
  logic [dlr_pkg::STRIDE_W-1:0] row_stride_q;
  logic [dlr_pkg::PBITS_W-1:0]  pixel_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= '0;
      row_stride_q <= '0;
      pixel_bits_q <= dlr_pkg::PIXEL_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dlr_pkg::CFG_FRAME_BASE: begin
          frame_base_q <= cfg_data_i[dlr_pkg::ADDR_W-1:0];
        end
        dlr_pkg::CFG_ROW_STRIDE: begin
          row_stride_q <= cfg_data_i[dlr_pkg::STRIDE_W-1:0];
        end
        dlr_pkg::CFG_PIXEL_BITS: begin
          pixel_bits_q <= cfg_data_i[dlr_pkg::PBITS_W-1:0];
        end
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // bytes per pixel: bits / 8 rounded down, any 6-bit value accepted
  logic [dlr_pkg::BPP_W-1:0] byte_step;
  assign byte_step = pixel_bits_q[dlr_pkg::PBITS_W-1:dlr_pkg::PBITS_W-dlr_pkg::BPP_W];

  dlr_pkg::cmd_t    cmd;
  dlr_pkg::status_t status;

  dlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dlr_datapath #(
    .CoordBits (COORD_BITS),
    .MaxSpan   (MAX_SPAN)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .x_start_i       (x_start_i),
    .y_start_i       (y_start_i),
    .x_end_i         (x_end_i),
    .y_end_i         (y_end_i),
    .line_color_i    (line_color_i),
    .frame_base_i    (frame_base_q),
    .row_stride_i    (row_stride_q),
    .byte_step_i     (byte_step),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_address_o (pixel_address_o),
    .pixel_color_o   (pixel_color_o),
    .last_pixel_o    (last_pixel_o),
    .cut_short_o     (cut_short_o)
  );

  // a taken segment request locks the input until its last pixel is in the output register
  `DLR_ASSERT_NXT(a_accept_locks_input, in_valid_i && !in_stall_o, in_stall_o)
  // truncation is only ever flagged on the closing pixel
  `DLR_ASSERT_IMP(a_cut_only_on_last, out_valid_o && cut_short_o, last_pixel_o)
  // a pending mid-line pixel means the walker is still busy
  `DLR_ASSERT_IMP(a_busy_mid_line, out_valid_o && !last_pixel_o, in_stall_o)

endmodule

`default_nettype wire

[sim/tb_dda_line_rasterizer_top.sv]
// self-checking testbench of the dda line rasterizer: segment driver, pixel monitor, scoreboard
module tb_dda_line_rasterizer_top;

  localparam int COORD_W      = 12;
  localparam int SPAN_LIMIT   = 63;
  localparam int COORD_MAX    = (1 << COORD_W) - 1;
  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES  = 400;     // long output hold-off of the pressure phase
  localparam int DRAIN_LIMIT  = 100000;  // cycles a phase may take to run dry
  localparam int TAIL_CYCLES  = 16;      // idle tail after the last pixel
  localparam int REPORT_MAX   = 10;

  // index with no register behind it, the block must ignore writes to it
  localparam logic [dlr_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0]          x0;
    logic [COORD_W-1:0]          y0;
    logic [COORD_W-1:0]          x1;
    logic [COORD_W-1:0]          y1;
    logic [dlr_pkg::COLOR_W-1:0] color;
  } segment_t;

  typedef struct packed {
    logic [COORD_W-1:0]          x;
    logic [COORD_W-1:0]          y;
    logic [dlr_pkg::ADDR_W-1:0]  addr;
    logic [dlr_pkg::COLOR_W-1:0] color;
    logic                        last;
    logic                        cut;
  } pixel_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // block inputs, all known from time zero
  logic                          cfg_we     = 1'b0;
  logic [dlr_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [dlr_pkg::CFG_W-1:0]     cfg_data   = '0;
  logic                          in_valid   = 1'b0;
  segment_t                      seg_on_bus = '0;
  logic                          out_stall  = 1'b0;

  // block outputs
  logic                        in_stall;
  logic                        out_valid;
  logic [COORD_W-1:0]          pixel_x;
  logic [COORD_W-1:0]          pixel_y;
  logic [dlr_pkg::ADDR_W-1:0]  pixel_address;
  logic [dlr_pkg::COLOR_W-1:0] pixel_color;
  logic                        last_pixel;
  logic                        cut_short;

  dda_line_rasterizer_top #(
    .COORD_BITS(COORD_W),
    .MAX_SPAN  (SPAN_LIMIT)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .x_start_i      (seg_on_bus.x0),
    .y_start_i      (seg_on_bus.y0),
    .x_end_i        (seg_on_bus.x1),
    .y_end_i        (seg_on_bus.y1),
    .line_color_i   (seg_on_bus.color),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .pixel_address_o(pixel_address),
    .pixel_color_o  (pixel_color),
    .last_pixel_o   (last_pixel),
    .cut_short_o    (cut_short)
  );

  // framebuffer settings as the block should hold them, reset values first
  logic [dlr_pkg::ADDR_W-1:0]   fb_base       = '0;
  logic [dlr_pkg::STRIDE_W-1:0] fb_stride     = '0;
  logic [dlr_pkg::PBITS_W-1:0]  fb_pixel_bits = dlr_pkg::PIXEL_BITS_RST;

  segment_t pending_segments[$];  // segments waiting to be offered
  pixel_t   expected_pixels[$];   // pixels predicted, oldest first

  // traffic shaping, set per phase by the sequencer
  int  sender_idle_pct = 0;
  int  recv_stall_pct  = 0;
  bit  hold_armed      = 1'b0;
  int  hold_count      = 0;

  // run statistics
  int failures          = 0;
  int segments_accepted = 0;
  int segments_cut      = 0;
  int pixels_checked    = 0;
  int reg_writes        = 0;

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= REPORT_MAX) $display("%t ERROR %s", $realtime, msg);
  endtask

  // expected pixels of one segment: k-th pixel at start + floor(k*d/span)
  task automatic predict_segment(input segment_t seg);
    logic               neg_x, neg_y, trunc;
    logic [COORD_W-1:0] ax, ay, span, n_steps;
    int unsigned        off_x, off_y;
    pixel_t             px;
    neg_x   = seg.x1 < seg.x0;
    neg_y   = seg.y1 < seg.y0;
    ax      = neg_x ? seg.x0 - seg.x1 : seg.x1 - seg.x0;
    ay      = neg_y ? seg.y0 - seg.y1 : seg.y1 - seg.y0;
    span    = (ax > ay) ? ax : ay;
    trunc   = span > SPAN_LIMIT;
    n_steps = trunc ? COORD_W'(SPAN_LIMIT) : span;
    if (trunc) segments_cut++;
    for (int k = 0; k <= int'(n_steps); k++) begin
      if (span == 0) begin
        off_x = 0;
        off_y = 0;
      end else begin
        // a falling axis rounds the magnitude up so the floor holds for negative deltas
        off_x = neg_x ? (k * ax + span - 1) / span : (k * ax) / span;
        off_y = neg_y ? (k * ay + span - 1) / span : (k * ay) / span;
      end
      px.x     = neg_x ? seg.x0 - off_x[COORD_W-1:0] : seg.x0 + off_x[COORD_W-1:0];
      px.y     = neg_y ? seg.y0 - off_y[COORD_W-1:0] : seg.y0 + off_y[COORD_W-1:0];
      px.addr  = fb_base + dlr_pkg::ADDR_W'(px.y) * dlr_pkg::ADDR_W'(fb_stride)
               + dlr_pkg::ADDR_W'(px.x) * dlr_pkg::ADDR_W'(fb_pixel_bits / 8);
      px.color = seg.color;
      px.last  = (k == int'(n_steps));
      px.cut   = px.last && trunc;
      expected_pixels.push_back(px);
    end
  endtask

  // segment driver: payload holds while stalled, next request picked when the bus is free
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_segment(seg_on_bus);
        segments_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_segments.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          seg_on_bus <= pending_segments.pop_front();
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output stall: one long hold-off when armed, random stalls otherwise
  always @(posedge clk) begin
    if (hold_armed && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // pixel monitor: every accepted pixel against the oldest prediction
  always @(posedge clk) begin
    pixel_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{pixel_x, pixel_y, pixel_address, pixel_color, last_pixel, cut_short};
      if (expected_pixels.size() == 0) begin
        report_failure($sformatf({"pixel with nothing expected: ",
                                  "x=%0d y=%0d addr=%h color=%h last=%b cut=%b"},
                                 got.x, got.y, got.addr, got.color, got.last, got.cut));
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (got.x !== want.x || got.y !== want.y || got.addr !== want.addr ||
            got.color !== want.color || got.last !== want.last || got.cut !== want.cut) begin
          report_failure($sformatf({"pixel mismatch: exp x=%0d y=%0d addr=%h color=%h last=%b cut=%b",
                                    " / got x=%0d y=%0d addr=%h color=%h last=%b cut=%b"},
                                   want.x, want.y, want.addr, want.color, want.last, want.cut,
                                   got.x, got.y, got.addr, got.color, got.last, got.cut));
        end
      end
    end
  end

  // register write through the plain write port, mirrored into the predictor
  task automatic write_reg(input logic [dlr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dlr_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dlr_pkg::CFG_FRAME_BASE: fb_base       = data[dlr_pkg::ADDR_W-1:0];
      dlr_pkg::CFG_ROW_STRIDE: fb_stride     = data[dlr_pkg::STRIDE_W-1:0];
      dlr_pkg::CFG_PIXEL_BITS: fb_pixel_bits = data[dlr_pkg::PBITS_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // wait until every segment is offered, taken and all its pixels are back
  task automatic drain_all();
    int waited;
    waited = 0;
    while ((pending_segments.size() != 0 || in_valid || expected_pixels.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      report_failure($sformatf("%0d pixels never arrived", expected_pixels.size()));
      expected_pixels.delete();
    end
  endtask

  function automatic segment_t make_seg(input int x0, input int y0, input int x1, input int y1,
                                        input logic [dlr_pkg::COLOR_W-1:0] color);
    segment_t seg;
    seg = '{COORD_W'(x0), COORD_W'(y0), COORD_W'(x1), COORD_W'(y1), color};
    return seg;
  endfunction

  // endpoint offset by d, mirrored back onto the screen if it falls off
  function automatic logic [COORD_W-1:0] offset_coord(input logic [COORD_W-1:0] p, input int d);
    int v;
    v = int'(p) + d;
    if (v < 0 || v > COORD_MAX) v = int'(p) - d;
    return COORD_W'(v);
  endfunction

  // mostly short lines, some around the span limit, a few with random endpoints
  function automatic segment_t random_segment();
    segment_t seg;
    int       pick, span, dx, dy;
    seg.color = $urandom();
    seg.x0    = COORD_W'($urandom_range(COORD_MAX));
    seg.y0    = COORD_W'($urandom_range(COORD_MAX));
    pick      = $urandom_range(99);
    if (pick < 8) begin
      seg.x1 = COORD_W'($urandom_range(COORD_MAX));
      seg.y1 = COORD_W'($urandom_range(COORD_MAX));
    end else begin
      span = (pick < 80) ? $urandom_range(19) : $urandom_range(70, 20);
      dx   = int'($urandom_range(2 * span)) - span;
      dy   = int'($urandom_range(2 * span)) - span;
      // one axis carries the full span
      if ($urandom_range(1)) dx = $urandom_range(1) ? span : -span;
      else                   dy = $urandom_range(1) ? span : -span;
      seg.x1 = offset_coord(seg.x0, dx);
      seg.y1 = offset_coord(seg.y0, dy);
    end
    return seg;
  endfunction

  task automatic queue_random(input int count);
    repeat (count) pending_segments.push_back(random_segment());
  endtask

  // phase sequencer
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed lines under the reset settings, no idling
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    pending_segments.push_back(make_seg(0, 0, 0, 0, 32'h0000_0000));               // single dot
    pending_segments.push_back(make_seg(4095, 4095, 4095, 4095, 32'hFFFF_FFFF));   // dot at far corner
    pending_segments.push_back(make_seg(10, 20, 25, 20, 32'h1234_5678));           // rightward
    pending_segments.push_back(make_seg(25, 20, 10, 20, 32'h8765_4321));           // leftward
    pending_segments.push_back(make_seg(100, 5, 100, 17, 32'hA5A5_A5A5));          // downward
    pending_segments.push_back(make_seg(100, 17, 100, 5, 32'h5A5A_5A5A));          // upward
    pending_segments.push_back(make_seg(50, 50, 60, 60, 32'h0F0F_0F0F));           // diagonals
    pending_segments.push_back(make_seg(60, 50, 50, 60, 32'hF0F0_F0F0));
    pending_segments.push_back(make_seg(50, 60, 60, 50, 32'h00FF_00FF));
    pending_segments.push_back(make_seg(60, 60, 50, 50, 32'hFF00_FF00));
    pending_segments.push_back(make_seg(300, 300, 307, 319, 32'hDEAD_BEEF));       // steep
    pending_segments.push_back(make_seg(300, 300, 281, 293, 32'hCAFE_F00D));       // shallow falling
    pending_segments.push_back(make_seg(1000, 2000, 1001, 1996, 32'h0000_0001));   // falling y, short
    pending_segments.push_back(make_seg(0, 0, 63, 17, 32'h8000_0000));             // exactly max span
    pending_segments.push_back(make_seg(63, 40, 0, 0, 32'h7FFF_FFFF));
    pending_segments.push_back(make_seg(0, 0, 64, 30, 32'h1111_1111));             // one step too long
    pending_segments.push_back(make_seg(0, 0, 4095, 4095, 32'h2222_2222));         // longest lines, cut
    pending_segments.push_back(make_seg(4095, 0, 0, 4095, 32'h3333_3333));
    pending_segments.push_back(make_seg(4095, 4095, 0, 1, 32'h4444_4444));
    pending_segments.push_back(make_seg(2048, 4095, 2047, 0, 32'h5555_5555));
    drain_all();

    // address wrap: top base, widest stride, one byte per pixel; sender idles
    write_reg(dlr_pkg::CFG_FRAME_BASE, 32'hFFFF_FFFF);
    write_reg(dlr_pkg::CFG_ROW_STRIDE, 32'h0000_FFFF);
    write_reg(dlr_pkg::CFG_PIXEL_BITS, 32'd8);
    sender_idle_pct = 65;
    recv_stall_pct  = 0;
    queue_random(65);
    drain_all();

    // random base and stride, junk above the stride field; receiver stalls
    write_reg(dlr_pkg::CFG_FRAME_BASE, $urandom());
    write_reg(dlr_pkg::CFG_ROW_STRIDE, $urandom());
    write_reg(dlr_pkg::CFG_PIXEL_BITS, 32'd24);
    sender_idle_pct = 0;
    recv_stall_pct  = 65;
    queue_random(65);
    drain_all();

    // zero base, zero byte step from junk data, unused index; both sides idle
    write_reg(dlr_pkg::CFG_FRAME_BASE, 32'h0000_0000);
    write_reg(dlr_pkg::CFG_ROW_STRIDE, {16'hFFFF, 16'($urandom())});
    write_reg(dlr_pkg::CFG_PIXEL_BITS, 32'hABCD_00C0);
    write_reg(CFG_IDX_UNUSED, $urandom());
    sender_idle_pct = 29;
    recv_stall_pct  = 29;
    queue_random(65);
    drain_all();

    // zero stride, widest odd pixel size; long hold-off with the sender pushing
    write_reg(dlr_pkg::CFG_FRAME_BASE, $urandom());
    write_reg(dlr_pkg::CFG_ROW_STRIDE, 32'h0000_0000);
    write_reg(dlr_pkg::CFG_PIXEL_BITS, {26'($urandom()), 6'h3F});
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_armed      = 1'b1;
    queue_random(65);
    drain_all();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d segments (%0d cut at the span limit), %0d pixels compared, %0d %s",
             segments_accepted, segments_cut, pixels_checked, reg_writes, "register writes");
    $display("traffic: free flow, sender gaps, receiver stalls, both, and a %0d-cycle %s",
             HOLD_CYCLES, "output hold-off");
    if (failures == 0) begin
      $display("dda_line_rasterizer_top regression: pass");
    end else begin
      $display("dda_line_rasterizer_top regression: fail");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #(CLK_PERIOD * 400000);
    $display("timeout with %0d pixels still expected", expected_pixels.size());
    $display("dda_line_rasterizer_top regression: fail");
    $finish;
  end

endmodule
